[hdl/lpp_pkg.sv]
// Shared types and constants for the logical page placement core.
// No dependencies; imported by lpp_datapath and logical_page_placement_core.
`default_nettype none

package lpp_pkg;

    localparam int PAGE_W   = 40;
    localparam int TOTAL_W  = 41;
    localparam int SUM_W    = 42;
    localparam int CH_W     = 8;
    localparam int SA_W     = 12;
    localparam int BP_W     = 16;
    localparam int CFG_W    = 41;
    localparam int IDX_W    = 3;
    localparam int NARROW   = 16;
    localparam int PIPE_N   = 97;

    typedef enum logic [1:0] {
        MODE_DEFAULT    = 2'd0,
        MODE_CONTIGUOUS = 2'd1,
        MODE_EXPLICIT   = 2'd2,
        MODE_INTERLEAVE = 2'd3
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_CHANNEL_COUNT  = 3'd0,
        REG_ALLOW_WIDE     = 3'd1,
        REG_SUBARRAY_COUNT = 3'd2,
        REG_PLACEMENT_MODE = 3'd3,
        REG_DEFAULT_CONTIG = 3'd4,
        REG_TOTAL_PAGES    = 3'd5,
        REG_BLOCK_PAGES    = 3'd6,
        REG_UNUSED         = 3'd7
    } t_reg_idx;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [CH_W-1:0]    nch;
        logic [SA_W-1:0]    nsa;
        logic [BP_W-1:0]    ppb;
        t_mode              mode;
        logic               contig;
        logic [TOTAL_W-1:0] total;
    } t_cfg;

    typedef struct packed {
        logic               ok;
        logic [CH_W-1:0]    channel;
        logic [PAGE_W-1:0]  channel_offset;
        logic [31:0]        subarray;
        logic [31:0]        pblock_tag;
        logic [31:0]        page_in_block;
    } t_res;

endpackage

`default_nettype wire

[hdl/lpp_datapath.sv]
// Pipelined placement datapath: bit-per-stage dividers, contiguous search,
// sub-array selection. Depends on lpp_pkg.
`default_nettype none

module lpp_datapath (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  wire [lpp_pkg::PAGE_W-1:0] i_logical_page,
    input  wire                       i_explicit_present,
    input  wire [lpp_pkg::CH_W-1:0]   i_explicit_channel,
    input  lpp_pkg::t_cfg             i_cfg,
    output logic                      o_valid,
    output lpp_pkg::t_res             o_res
);
    import lpp_pkg::*;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              present;
        logic [CH_W-1:0]   xch;
        logic [SUM_W-1:0]  tn;
        logic [BP_W-1:0]   r1;
        logic [PAGE_W-1:0] q1;
        logic [CH_W-1:0]   r2;
        logic [PAGE_W-1:0] q2;
        logic [CH_W-1:0]   r3;
        logic [SUM_W-1:0]  q3;
        logic [CH_W-1:0]   r4;
        logic [SA_W-1:0]   q4;
        logic [SUM_W-1:0]  per;
        logic              sat;
        logic [PAGE_W-1:0] r5;
        logic [CH_W-1:0]   q5;
        logic              over;
        logic [CH_W-1:0]   ch;
        logic [49:0]       prod;
        logic [PAGE_W-1:0] loc;
        logic              ok;
        logic [19:0]       first;
        logic [SA_W-1:0]   cnt;
        logic [SA_W-1:0]   r6;
        logic [31:0]       sub;
    } t_item;

    t_item            r_pipe [PIPE_N];
    t_item            n_pipe [PIPE_N];
    logic [PIPE_N-1:0] r_vld;
    t_item            entry;

    function automatic t_item stage_fn(input int s, input t_item a, input t_cfg c);
        t_item           b;
        logic [16:0]     t1;
        logic [8:0]      t8;
        logic [12:0]     t12;
        logic [49:0]     cmp;
        logic [CH_W-1:0] qc;
        logic [SA_W-1:0] pch;
        logic [SA_W:0]   rest;
        b = a;
        // one restoring step of each running division
        if (s < 42) begin
            t8 = {a.r3, a.tn[41-s]};
            if (t8 >= {1'b0, c.nch}) begin
                t8 = t8 - {1'b0, c.nch};
                b.q3 = {a.q3[SUM_W-2:0], 1'b1};
            end else begin
                b.q3 = {a.q3[SUM_W-2:0], 1'b0};
            end
            b.r3 = t8[CH_W-1:0];
        end
        if (s < 40) begin
            t1 = {a.r1, a.page[39-s]};
            if (t1 >= {1'b0, c.ppb}) begin
                t1 = t1 - {1'b0, c.ppb};
                b.q1 = {a.q1[PAGE_W-2:0], 1'b1};
            end else begin
                b.q1 = {a.q1[PAGE_W-2:0], 1'b0};
            end
            b.r1 = t1[BP_W-1:0];
            t8 = {a.r2, a.page[39-s]};
            if (t8 >= {1'b0, c.nch}) begin
                t8 = t8 - {1'b0, c.nch};
                b.q2 = {a.q2[PAGE_W-2:0], 1'b1};
            end else begin
                b.q2 = {a.q2[PAGE_W-2:0], 1'b0};
            end
            b.r2 = t8[CH_W-1:0];
        end
        if (s < 12) begin
            t8 = {a.r4, c.nsa[11-s]};
            if (t8 >= {1'b0, c.nch}) begin
                t8 = t8 - {1'b0, c.nch};
                b.q4 = {a.q4[SA_W-2:0], 1'b1};
            end else begin
                b.q4 = {a.q4[SA_W-2:0], 1'b0};
            end
            b.r4 = t8[CH_W-1:0];
        end
        if (s == 42) begin
            b.per = (a.q3 == '0) ? SUM_W'(1) : a.q3;
            b.sat = {10'd0, a.page} >= {b.per, 8'd0};
            b.r5  = a.page;
            b.q5  = '0;
        end
        // contiguous quotient, eight bits, largest weight first
        if (s >= 43 && s <= 50) begin
            cmp = {8'd0, a.per} << (50 - s);
            if ({10'd0, a.r5} >= cmp) begin
                b.r5 = a.r5 - cmp[PAGE_W-1:0];
                b.q5[50-s] = 1'b1;
            end
        end
        if (s == 51) begin
            qc     = a.sat ? {CH_W{1'b1}} : a.q5;
            b.over = qc >= c.nch;
            b.ch   = b.over ? c.nch - 1'b1 : qc;
            b.prod = 50'((c.nch - 1'b1) * a.per);
        end
        if (s == 52) begin
            b.ok = (a.q1[PAGE_W-1:31] == '0);
            if (c.mode == MODE_EXPLICIT) begin
                if (!a.present || a.xch >= c.nch) b.ok = 1'b0;
                b.ch  = a.xch;
                b.loc = a.page;
            end else if (c.contig) begin
                b.loc = a.over ? a.page - a.prod[PAGE_W-1:0] : a.r5;
            end else begin
                b.ch  = a.r2;
                b.loc = a.q2;
            end
        end
        if (s == 53) begin
            pch     = (a.q4 == '0) ? SA_W'(1) : a.q4;
            b.first = 20'(a.ch * pch);
        end
        if (s == 54) begin
            pch = (a.q4 == '0) ? SA_W'(1) : a.q4;
            if (a.ch == c.nch - 1'b1) begin
                rest  = (a.first < {8'd0, c.nsa}) ? 13'({8'd0, c.nsa} - a.first) : '0;
                b.cnt = rest[SA_W-1:0];
            end else begin
                b.cnt = pch;
            end
            if (b.cnt == '0) b.cnt = SA_W'(1);
            b.r6 = '0;
        end
        if (s >= 55 && s <= 94) begin
            t12 = {a.r6, a.loc[94-s]};
            if (t12 >= {1'b0, a.cnt}) t12 = t12 - {1'b0, a.cnt};
            b.r6 = t12[SA_W-1:0];
        end
        if (s == 95) begin
            b.sub = 32'(a.first) + 32'(a.r6);
        end
        return b;
    endfunction

    always_comb begin
        entry         = '0;
        entry.page    = i_logical_page;
        entry.present = i_explicit_present;
        entry.xch     = i_explicit_channel;
        entry.tn      = {1'b0, i_cfg.total} + SUM_W'(i_cfg.nch) - SUM_W'(1);
        n_pipe[0]     = entry;
        for (int s = 0; s < PIPE_N - 1; s++) begin
            n_pipe[s+1] = stage_fn(s, r_pipe[s], i_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[PIPE_N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < PIPE_N; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    always_comb begin
        o_valid = r_vld[PIPE_N-1];
        o_res.ok = r_pipe[PIPE_N-1].ok;
        if (r_pipe[PIPE_N-1].ok) begin
            o_res.channel        = r_pipe[PIPE_N-1].ch;
            o_res.channel_offset = r_pipe[PIPE_N-1].loc;
            o_res.subarray       = r_pipe[PIPE_N-1].sub;
            o_res.pblock_tag     = {1'b1, r_pipe[PIPE_N-1].q1[30:0]};
            o_res.page_in_block  = {16'd0, r_pipe[PIPE_N-1].r1};
        end else begin
            o_res.channel        = '0;
            o_res.channel_offset = '0;
            o_res.subarray       = '1;
            o_res.pblock_tag     = '1;
            o_res.page_in_block  = '1;
        end
    end

endmodule

`default_nettype wire

[hdl/logical_page_placement_core.sv]
// Logical page placement core: configuration registers and handshake.
// Depends on lpp_pkg and lpp_datapath.
//
// One beat in, one beat out. A page's result appears on the outputs once the beat
// has passed all 97 pipeline registers, the input one included; the pipeline takes
// a new beat every cycle while o_stall is low. The depth comes from the
// bit-per-stage dividers: channel slice size (42 steps), contiguous quotient
// (8 steps) and sub-array remainder (40 steps) run in series. The whole pipe
// advances together, so o_stall follows i_stall while a result is held.
`default_nettype none

module logical_page_placement_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [lpp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire [lpp_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire [lpp_pkg::PAGE_W-1:0]  i_logical_page,
    input  wire                        i_explicit_present,
    input  wire [lpp_pkg::CH_W-1:0]    i_explicit_channel,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic                       o_valid_res,
    output logic [lpp_pkg::CH_W-1:0]   o_channel,
    output logic [lpp_pkg::PAGE_W-1:0] o_channel_offset,
    output logic [31:0]                o_subarray,
    output logic [31:0]                o_pblock_tag,
    output logic [31:0]                o_page_in_block
);
    import lpp_pkg::*;

    logic [CH_W-1:0]    r_channel_count;
    logic               r_allow_wide;
    logic [SA_W-1:0]    r_subarray_count;
    t_mode              r_mode;
    logic               r_default_contig;
    logic [TOTAL_W-1:0] r_total_pages;
    logic [BP_W-1:0]    r_block_pages;

    t_cfg        cfg;
    t_res        res;
    logic        en;
    logic        out_vld;
    logic [CH_W-1:0] n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count  <= CH_W'(1);
            r_allow_wide     <= 1'b0;
            r_subarray_count <= SA_W'(1);
            r_mode           <= MODE_DEFAULT;
            r_default_contig <= 1'b0;
            r_total_pages    <= '0;
            r_block_pages    <= BP_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CHANNEL_COUNT:  r_channel_count  <= i_cfg_wdata[CH_W-1:0];
                REG_ALLOW_WIDE:     r_allow_wide     <= i_cfg_wdata[0];
                REG_SUBARRAY_COUNT: r_subarray_count <= i_cfg_wdata[SA_W-1:0];
                REG_PLACEMENT_MODE: r_mode           <= t_mode'(i_cfg_wdata[1:0]);
                REG_DEFAULT_CONTIG: r_default_contig <= i_cfg_wdata[0];
                REG_TOTAL_PAGES:    r_total_pages    <= i_cfg_wdata[TOTAL_W-1:0];
                REG_BLOCK_PAGES:    r_block_pages    <= i_cfg_wdata[BP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.nsa = (r_subarray_count == '0) ? SA_W'(1) : r_subarray_count;
        n_ch    = (r_channel_count == '0) ? CH_W'(1) : r_channel_count;
        if (n_ch > CH_W'(NARROW) && !r_allow_wide) n_ch = CH_W'(NARROW);
        if ({4'd0, n_ch} > cfg.nsa) n_ch = cfg.nsa[CH_W-1:0];
        cfg.nch    = n_ch;
        cfg.ppb    = (r_block_pages == '0) ? BP_W'(1) : r_block_pages;
        cfg.mode   = r_mode;
        cfg.contig = (r_mode == MODE_CONTIGUOUS) ||
                     (r_mode == MODE_DEFAULT && r_default_contig);
        cfg.total  = r_total_pages;
    end

    // advance the whole pipe unless the held result is stalled
    assign en      = !(out_vld && i_stall);
    assign o_stall = !en;

    lpp_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (en),
        .i_valid            (i_valid),
        .i_logical_page     (i_logical_page),
        .i_explicit_present (i_explicit_present),
        .i_explicit_channel (i_explicit_channel),
        .i_cfg              (cfg),
        .o_valid            (out_vld),
        .o_res              (res)
    );

    assign o_valid          = out_vld;
    assign o_valid_res      = res.ok;
    assign o_channel        = res.channel;
    assign o_channel_offset = res.channel_offset;
    assign o_subarray       = res.subarray;
    assign o_pblock_tag     = res.pblock_tag;
    assign o_page_in_block  = res.page_in_block;

endmodule

`default_nettype wire
